/* sv/aut_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aut_pkg
// Shared constants and types of the abnormal unplug tracker.
// ----------------------------------------------------------------------------
package aut_pkg;

  localparam int SLOTS_DEF = 8;

  // field widths
  localparam int CMD_W     = 3;
  localparam int TIME_W    = 32;
  localparam int PROTO_W   = 2;
  localparam int WIN_W     = 16;
  localparam int LIMIT_W   = 4;
  localparam int OUT_CNT_W = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int LEVEL_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PLUG     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TIMER    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PROTO    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHARGER  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRESENCE = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABN_INTERVAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABN_LIMIT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 8'd3;

  // register reset values
  localparam logic [WIN_W-1:0]   KEEP_WINDOW_RST  = 16'd20000;
  localparam logic [WIN_W-1:0]   ABN_INTERVAL_RST = 16'd1000;
  localparam logic [LIMIT_W-1:0] ABN_LIMIT_RST    = 4'd3;
  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST  = 4'd3;

  localparam logic [LEVEL_W-1:0] GUARD_LEVEL = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
  localparam logic [PROTO_W-1:0] PROTO_NONE  = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_BC12  = 2'd1;
  localparam logic [1:0]         REPORT_UNKNOWN = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_COUNT_END,
    ST_READ,
    ST_CHECK,
    ST_FINISH,
    ST_RESP
  } aut_state_t;

endpackage
`default_nettype wire

/* sv/aut_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aut_if
// Channel interfaces: event input, result output and register write.
// ----------------------------------------------------------------------------
interface aut_in_if;
  import aut_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic               plugged;
  logic               cc_attached;
  logic [TIME_W-1:0]  now_ms;
  logic [PROTO_W-1:0] protocol_code;
  logic               charger_is_usb_data;

  modport source (output valid, cmd, plugged, cc_attached, now_ms, protocol_code,
                  charger_is_usb_data, input ready);
  modport sink (input valid, cmd, plugged, cc_attached, now_ms, protocol_code,
                charger_is_usb_data, output ready);
endinterface

interface aut_out_if;
  import aut_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 conn_retain;
  logic [OUT_CNT_W-1:0] marked_count;
  logic                 start_retry_timer;
  logic                 wake_request;
  logic                 event_ignored;

  modport source (output valid, conn_retain, marked_count, start_retry_timer,
                  wake_request, event_ignored, input ready);
  modport sink (input valid, conn_retain, marked_count, start_retry_timer,
                wake_request, event_ignored, output ready);
endinterface

interface aut_cfg_if;
  import aut_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/abnormal_unplug_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence: timer, protocol, charger, presence-high and dropped plug reports pass
//   EXEC, RESP; a replug EXEC, READ, CHECK, RESP; an unplug or a presence-low
//   count reads each slot in COUNT, one read per cycle, then COUNT_END, FINISH, RESP.
// Throughput: one event at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; per-slot valid bits make every slot read as zero
//   at once, so no clearing pass runs.
// ----------------------------------------------------------------------------
// abnormal_unplug_tracker
// Ring of unplug times in RAM with abnormal marks, window count and a
// three-level disconnect guard driven by protocol, presence and charger events.
// ----------------------------------------------------------------------------
module abnormal_unplug_tracker #(
  parameter int SLOTS = aut_pkg::SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  aut_in_if.sink   in_ch,
  aut_out_if.source out_ch,
  aut_cfg_if.sink  cfg_ch
);
  import aut_pkg::*;

  localparam int IW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int CXW = (CW > LIMIT_W) ? CW : LIMIT_W;

  function automatic logic still_ahead(input logic [TIME_W-1:0] t,
                                       input logic [WIN_W-1:0]  win,
                                       input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = t + TIME_W'(win) - now;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  // configuration
  logic [WIN_W-1:0]   keep_win_r, abn_int_r;
  logic [LIMIT_W-1:0] abn_limit_r, retry_limit_r;

  // latched event
  logic [CMD_W-1:0]   it_cmd_r;
  logic               it_plugged_r, it_cc_r, it_usb_r;
  logic [TIME_W-1:0]  it_now_r;
  logic [PROTO_W-1:0] it_proto_r;

  // control state
  aut_state_t         state_r, state_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic [1:0]         last_report_r, last_report_nxt;
  logic               last_plug_r, last_plug_nxt;
  logic               retain_r, retain_nxt;
  logic [LIMIT_W-1:0] retry_r, retry_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [PROTO_W-1:0] proto_type_r, proto_type_nxt;
  logic               present_r, present_nxt;
  logic [SLOTS-1:0]   marks_r, marks_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;

  // walk and result staging
  logic [IW-1:0]      cnt_idx_r, cnt_idx_nxt;
  logic [IW-1:0]      eval_idx_r, eval_idx_nxt;
  logic               eval_r, eval_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               res_start_r, res_start_nxt;
  logic               res_wake_r, res_wake_nxt;
  logic               res_ign_r, res_ign_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_keep_r, out_keep_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                 out_start_r, out_start_nxt;
  logic                 out_wake_r, out_wake_nxt;
  logic                 out_ign_r, out_ign_nxt;

  // RAM
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [TIME_W-1:0] ram_q;
  logic [TIME_W-1:0] eval_time, slot_time;

  logic              in_fire;
  logic              plug_drop;
  logic              out_free;
  logic [CXW-1:0]    count_x;
  logic [LEVEL_W-1:0] guard_lvl;
  logic [PROTO_W-1:0] proto_eff;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign count_x      = CXW'(count_r);

  assign plug_drop = ((level_r >= GUARD_LEVEL) && !it_plugged_r) ||
                     (last_report_r == {1'b0, it_plugged_r});
  assign proto_eff = (it_proto_r != PROTO_NONE) ? it_proto_r : proto_type_r;
  assign guard_lvl = (count_x >= CXW'(GUARD_LEVEL)) ? GUARD_LEVEL : level_r;

  // the sequencer never reads and writes the RAM in the same cycle
  assign ram_re    = (state_r == ST_COUNT) || (state_r == ST_READ);
  assign ram_raddr = (state_r == ST_COUNT) ? cnt_idx_r : slot_r;
  assign ram_we    = (state_r == ST_FINISH) && (it_cmd_r == CMD_PLUG);

  // a slot never written reads as zero
  assign eval_time = valid_r[eval_idx_r] ? ram_q : '0;
  assign slot_time = valid_r[slot_r] ? ram_q : '0;

  aut_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOTS)
  ) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (it_now_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        if (it_cmd_r == CMD_PLUG && !plug_drop) begin
          state_nxt = it_plugged_r ? ST_READ : ST_COUNT;
        end else if (it_cmd_r == CMD_PRESENCE && proto_type_r == PROTO_BC12 &&
                     !it_plugged_r) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (cnt_idx_r == IW'(SLOTS - 1)) state_nxt = ST_COUNT_END;
      end
      ST_COUNT_END: state_nxt = ST_FINISH;
      ST_READ:      state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = ST_RESP;
      ST_FINISH:    state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    slot_nxt        = slot_r;
    last_report_nxt = last_report_r;
    last_plug_nxt   = last_plug_r;
    retain_nxt      = retain_r;
    retry_nxt       = retry_r;
    level_nxt       = level_r;
    proto_type_nxt  = proto_type_r;
    present_nxt     = present_r;
    marks_nxt       = marks_r;
    valid_nxt       = valid_r;
    cnt_idx_nxt     = cnt_idx_r;
    eval_idx_nxt    = cnt_idx_r;
    eval_nxt        = (state_r == ST_COUNT);
    count_nxt       = count_r;
    res_start_nxt   = res_start_r;
    res_wake_nxt    = res_wake_r;
    res_ign_nxt     = res_ign_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_keep_nxt    = out_keep_r;
    out_cnt_nxt     = out_cnt_r;
    out_start_nxt   = out_start_r;
    out_wake_nxt    = out_wake_r;
    out_ign_nxt     = out_ign_r;

    // accumulate the slot read in the previous cycle
    if (eval_r && marks_r[eval_idx_r] && still_ahead(eval_time, keep_win_r, it_now_r)) begin
      count_nxt = count_r + CW'(1);
    end

    unique case (state_r)
      ST_EXEC: begin
        count_nxt     = '0;
        cnt_idx_nxt   = '0;
        res_start_nxt = 1'b0;
        res_wake_nxt  = 1'b0;
        res_ign_nxt   = 1'b0;
        case (it_cmd_r)
          CMD_PLUG: begin
            if (plug_drop) begin
              res_ign_nxt = 1'b1;
            end else begin
              last_report_nxt = {1'b0, it_plugged_r};
              last_plug_nxt   = it_plugged_r;
              if (!it_plugged_r) begin
                retry_nxt = '0;
                // advance the ring on an unplug that follows a plug
                if (last_plug_r) begin
                  slot_nxt = (slot_r == IW'(SLOTS - 1)) ? '0 : slot_r + IW'(1);
                end
              end
            end
          end
          CMD_TIMER: begin
            if (!last_plug_r) begin
              marks_nxt  = '0;
              retain_nxt = 1'b0;
              if (retry_r < retry_limit_r) begin
                retry_nxt     = retry_r + LIMIT_W'(1);
                res_wake_nxt  = 1'b1;
                res_start_nxt = 1'b1;
              end
            end
          end
          CMD_PROTO: begin
            proto_type_nxt = proto_eff;
            if (proto_eff != PROTO_BC12) level_nxt = LEVEL_ONE;
          end
          CMD_CHARGER: begin
            if (it_usb_r) begin
              retain_nxt = 1'b0;
              level_nxt  = GUARD_LEVEL;
            end
          end
          CMD_PRESENCE: begin
            present_nxt = it_plugged_r;
            if (proto_type_r != PROTO_BC12) level_nxt = LEVEL_ONE;
          end
          default: ;
        endcase
      end
      ST_COUNT: begin
        cnt_idx_nxt = cnt_idx_r + IW'(1);
      end
      ST_CHECK: begin
        if (still_ahead(slot_time, abn_int_r, it_now_r)) marks_nxt[slot_r] = 1'b1;
      end
      ST_FINISH: begin
        if (it_cmd_r == CMD_PLUG) begin
          valid_nxt[slot_r] = 1'b1;
          res_wake_nxt      = 1'b1;
          if (it_cc_r) begin
            retain_nxt    = (count_x < CXW'(abn_limit_r));
            res_start_nxt = 1'b1;
          end else begin
            retain_nxt = 1'b0;
            marks_nxt  = '0;
          end
        end else begin
          level_nxt = guard_lvl;
          if (guard_lvl >= GUARD_LEVEL) begin
            retain_nxt = 1'b0;
            marks_nxt  = '0;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_keep_nxt  = retain_r;
          out_cnt_nxt   = (count_x > CXW'(15)) ? OUT_CNT_W'(15) : count_x[OUT_CNT_W-1:0];
          out_start_nxt = res_start_r;
          out_wake_nxt  = res_wake_r;
          out_ign_nxt   = res_ign_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      slot_r        <= '0;
      last_report_r <= REPORT_UNKNOWN;
      last_plug_r   <= 1'b0;
      retain_r      <= 1'b0;
      retry_r       <= '0;
      level_r       <= '0;
      proto_type_r  <= PROTO_NONE;
      present_r     <= 1'b0;
      marks_r       <= '0;
      valid_r       <= '0;
      eval_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      keep_win_r    <= KEEP_WINDOW_RST;
      abn_int_r     <= ABN_INTERVAL_RST;
      abn_limit_r   <= ABN_LIMIT_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
    end else begin
      state_r       <= state_nxt;
      slot_r        <= slot_nxt;
      last_report_r <= last_report_nxt;
      last_plug_r   <= last_plug_nxt;
      retain_r      <= retain_nxt;
      retry_r       <= retry_nxt;
      level_r       <= level_nxt;
      proto_type_r  <= proto_type_nxt;
      present_r     <= present_nxt;
      marks_r       <= marks_nxt;
      valid_r       <= valid_nxt;
      eval_r        <= eval_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_KEEP_WINDOW:  keep_win_r    <= cfg_ch.data[WIN_W-1:0];
          REG_ABN_INTERVAL: abn_int_r     <= cfg_ch.data[WIN_W-1:0];
          REG_ABN_LIMIT:    abn_limit_r   <= cfg_ch.data[LIMIT_W-1:0];
          REG_RETRY_LIMIT:  retry_limit_r <= cfg_ch.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_cmd_r     <= in_ch.cmd;
      it_plugged_r <= in_ch.plugged;
      it_cc_r      <= in_ch.cc_attached;
      it_now_r     <= in_ch.now_ms;
      it_proto_r   <= in_ch.protocol_code;
      it_usb_r     <= in_ch.charger_is_usb_data;
    end
    cnt_idx_r   <= cnt_idx_nxt;
    eval_idx_r  <= eval_idx_nxt;
    count_r     <= count_nxt;
    res_start_r <= res_start_nxt;
    res_wake_r  <= res_wake_nxt;
    res_ign_r   <= res_ign_nxt;
    out_keep_r  <= out_keep_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_start_r <= out_start_nxt;
    out_wake_r  <= out_wake_nxt;
    out_ign_r   <= out_ign_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.conn_retain       = out_keep_r;
  assign out_ch.marked_count      = out_cnt_r;
  assign out_ch.start_retry_timer = out_start_r;
  assign out_ch.wake_request      = out_wake_r;
  assign out_ch.event_ignored     = out_ign_r;

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("accepted transaction did not start execution");

  a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("slot RAM read and written in the same cycle");

  a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= GUARD_LEVEL)
    else $error("disconnect level above guard level");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("result raised outside the response state");

  a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    eval_r |-> $past(state_r) == ST_COUNT)
    else $error("count evaluation without a slot read");

endmodule
`default_nettype wire

/* sv/aut_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aut_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aut_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
